// ===== src/magnitude_sort_with_streak_top_assert.svh =====
// assertion macros for the magnitude sort block
`ifndef MAGNITUDE_SORT_WITH_STREAK_TOP_ASSERT_SVH
`define MAGNITUDE_SORT_WITH_STREAK_TOP_ASSERT_SVH
`define MSS_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define MSS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== src/mss_pkg.sv =====
// package for the magnitude sort block: types, constants
`default_nettype none
package mss_pkg;
  localparam int Depth = 64;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  localparam logic [2:0] ModeList = 3'd0;
  localparam logic [2:0] ModePos = 3'd1;
  localparam logic [2:0] ModeNeg = 3'd2;
  localparam logic [2:0] ModeBang = 3'd3;
  localparam logic [2:0] ModeBig = 3'd4;

  localparam logic [0:0] RegDesc = 1'b0;
  localparam logic [0:0] RegMode = 1'b1;

  typedef struct packed {
    logic signed [31:0] value;
    logic last;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic [5:0] position;
    logic [6:0] run_length;
    logic bang;
    logic final_res;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SORT, ST_KEY, ST_CMP, ST_PUT, ST_SCAN, ST_EMIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sort_start;
    logic fetch;
    logic key_take;
    logic shift;
    logic place;
    logic scan_clear;
    logic scan_step;
    logic emit_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic key_more;
    logic move;
    logic at_bottom;
    logic scan_done;
    logic emit_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/magnitude_sort_with_streak_top.sv =====
// magnitude sort with streak: top level
// operation: load n values, then insertion-sort them by magnitude in the store
// sort time is set by the single compare-and-shift unit with registered store reads
// streak and bang modes then scan the sorted entries, then hold one result beat
// throughput: one value per cycle while loading; list results one per cycle while out_ready is high
// synchronous active-high reset empties the store and clears the control and scan registers
`default_nettype none
module magnitude_sort_with_streak_top import mss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  logic descending;
  logic [2:0] mode;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
      mode <= ModeList;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[2]) begin
      descending <= pwdata[0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2]) begin
      mode <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        RegDesc: prdata = {31'd0, descending};
        RegMode: prdata = {29'd0, mode};
        default: prdata = '0;
      endcase
    end
  end

  mss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .mode(mode),
    .sts(sts), .cmd(cmd)
  );

  mss_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_beat(in_data),
    .descending(descending), .mode(mode), .out_beat(out_data)
  );
endmodule
`default_nettype wire

// ===== src/mss_datapath.sv =====
// datapath: entry store, insertion sort unit, scan and emit
`default_nettype none
module mss_datapath import mss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  input  wire in_beat_t  in_beat,
  input  wire logic      descending,
  input  wire logic [2:0] mode,
  output out_beat_t      out_beat
);
  logic [31:0] val [Depth];
  logic [IdxW-1:0] pos [Depth];
  logic [IdxW-1:0] raddr;
  logic [31:0] rd_val;
  logic [IdxW-1:0] rd_pos;
  logic [CntW-1:0] count;
  logic [6:0] latest;
  logic [CntW-1:0] i;
  logic [CntW-1:0] j;
  logic [31:0] kv;
  logic [IdxW-1:0] kp;
  logic [CntW-1:0] n;
  logic run;
  logic [6:0] streak;
  logic bang;
  logic is_bang;
  logic desc;
  logic [31:0] km;
  logic [31:0] pm;
  logic move;
  logic full;
  logic scan_adv;
  logic sv_pos;
  logic sv_neg;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  assign full = count == CntW'(Depth);
  assign is_bang = (mode == ModeBang) || (mode == ModeBig);
  assign desc = is_bang ? 1'b1 : descending;
  assign km = mag(kv);
  assign pm = mag(rd_val);
  assign move = desc ? (pm < km) : (pm > km);
  assign sv_pos = (rd_val != 32'd0) && !rd_val[31];
  assign sv_neg = rd_val[31];
  assign scan_adv = cmd.scan_step && run && (n < count);

  assign sts.last_in = in_beat.last;
  assign sts.key_more = i < count;
  assign sts.move = move;
  assign sts.at_bottom = j == CntW'(1);
  assign sts.scan_done = !run || (n >= count);
  assign sts.emit_last = (n + 1'b1) >= count;

  // read address for the registered store read
  always_comb begin
    raddr = IdxW'(n);
    if (cmd.fetch) begin
      raddr = IdxW'(i);
    end else if (cmd.key_take) begin
      raddr = IdxW'(i - 1'b1);
    end else if (cmd.shift) begin
      raddr = IdxW'(j - 2'd2);
    end else if (cmd.scan_clear) begin
      raddr = '0;
    end else if (scan_adv || cmd.emit_step) begin
      raddr = IdxW'(n + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      val[IdxW'(count)] <= in_beat.value;
      pos[IdxW'(count)] <= IdxW'(count);
    end else if (cmd.shift) begin
      val[IdxW'(j)] <= rd_val;
      pos[IdxW'(j)] <= rd_pos;
    end else if (cmd.place) begin
      val[IdxW'(j)] <= kv;
      pos[IdxW'(j)] <= kp;
    end
    rd_val <= val[raddr];
    rd_pos <= pos[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      latest <= '1;
    end else if (cmd.load && !full) begin
      count <= count + 1'b1;
      if (in_beat.value != 32'sd0 && !in_beat.value[31]) begin
        latest <= 7'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else if (cmd.sort_start) begin
      i <= CntW'(1);
    end else if (cmd.place) begin
      i <= i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_take) begin
      kv <= rd_val;
      kp <= rd_pos;
      j <= i;
    end else if (cmd.shift) begin
      j <= j - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clear) begin
      n <= '0;
      run <= 1'b1;
      streak <= '0;
      bang <= 1'b0;
    end else if (scan_adv) begin
      n <= n + 1'b1;
      if (is_bang) begin
        if (!sv_pos) begin
          run <= 1'b0;
        end else if ({1'b0, rd_pos} == latest &&
                     (mode == ModeBang || n == '0)) begin
          bang <= 1'b1;
        end
      end else if ((mode == ModePos) ? sv_pos : sv_neg) begin
        streak <= streak + 1'b1;
      end else begin
        run <= 1'b0;
      end
    end else if (cmd.emit_step) begin
      n <= n + 1'b1;
    end
  end

  always_comb begin
    out_beat = '0;
    out_beat.final_res = 1'b1;
    if (mode == ModePos || mode == ModeNeg) begin
      out_beat.run_length = streak;
    end else if (is_bang) begin
      out_beat.bang = bang;
    end else begin
      out_beat.sorted_value = rd_val;
      out_beat.position = rd_pos;
      out_beat.final_res = sts.emit_last;
    end
  end
endmodule
`default_nettype wire

// ===== src/mss_ctrl.sv =====
// controller state machine for the magnitude sort block
`default_nettype none
`include "magnitude_sort_with_streak_top_assert.svh"
module mss_ctrl import mss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire logic [2:0] mode,
  input  wire sts_t       sts,
  output cmd_t            cmd
);
  state_t state, state_next;
  logic list_mode;

  assign list_mode = !(mode == ModePos || mode == ModeNeg ||
                       mode == ModeBang || mode == ModeBig);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.last_in) begin
            cmd.sort_start = 1'b1;
            state_next = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (sts.key_more) begin
          cmd.fetch = 1'b1;
          state_next = ST_KEY;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next = list_mode ? ST_EMIT : ST_SCAN;
        end
      end
      ST_KEY: begin
        cmd.key_take = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sts.move) begin
          cmd.shift = 1'b1;
          if (sts.at_bottom) begin
            state_next = ST_PUT;
          end
        end else begin
          cmd.place = 1'b1;
          state_next = ST_SORT;
        end
      end
      ST_PUT: begin
        cmd.place = 1'b1;
        state_next = ST_SORT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          state_next = ST_DONE;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  `MSS_ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
  `MSS_ASSERT_NEXT(a_last_sorts, in_valid && in_ready && sts.last_in, state == ST_SORT)
  `MSS_ASSERT_NEXT(a_clear_loads, cmd.clear, state == ST_LOAD)
endmodule
`default_nettype wire
